// ===== rtl/sncv_pkg.sv =====
`timescale 1ns / 1ps

package sncv_pkg;

    // Segment limits of CC-ORG-UNIQUE[-CHECK]
    localparam int CC_CHARS         = 2;
    localparam int ORG_MIN_CHARS    = 2;
    localparam int ORG_MAX_CHARS    = 6;
    localparam int UNIQUE_MIN_CHARS = 8;
    localparam int UNIQUE_MAX_CHARS = 16;
    localparam int CHECK_MIN_CHARS  = 1;
    localparam int CHECK_MAX_CHARS  = 2;

    localparam logic [4:0] SEG_LEN_MAX   = 5'd31;
    localparam logic [6:0] TOTAL_LEN_MAX = 7'd127;

    localparam logic [5:0] MAX_LENGTH_RESET = 6'd32;

    // Segment indexes
    localparam logic [2:0] SEG_CC     = 3'd0;
    localparam logic [2:0] SEG_ORG    = 3'd1;
    localparam logic [2:0] SEG_UNIQUE = 3'd2;
    localparam logic [2:0] SEG_CHECK  = 3'd3;

    // ASCII codes
    localparam logic [7:0] CH_DASH = 8'h2D;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_A    = 8'h41;
    localparam logic [7:0] CH_Z    = 8'h5A;

    // mod 97 by reciprocal: floor(x / 97) = (x * 676) >> 16 for x < 1024
    localparam logic [9:0] MOD97_RECIP = 10'd676;
    localparam logic [9:0] MOD97       = 10'd97;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_EMPTY    = 2'd1,
        STATUS_TOO_LONG = 2'd2,
        STATUS_BAD      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_LUHN  = 2'd1,
        KIND_MOD97 = 2'd2
    } kind_t;

    typedef struct packed {
        logic       is_dash;
        logic       is_upper;   // A-Z
        logic       is_digit;   // 0-9
        logic       crock_ok;   // upper-case Crockford Base32
        logic [4:0] crock_val;
        logic [5:0] mod_val;    // digit value, or letter - 'A' + 10
    } char_class_t;

    typedef struct packed {
        status_t status;
        kind_t   kind;
        logic    pass;
    } result_t;

    function automatic logic seg_len_ok(input logic [2:0] idx, input logic [4:0] len);
        logic ok;
        begin
            case (idx)
                SEG_CC:     ok = (len == 5'(CC_CHARS));
                SEG_ORG:    ok = (len >= 5'(ORG_MIN_CHARS)) && (len <= 5'(ORG_MAX_CHARS));
                SEG_UNIQUE: ok = (len >= 5'(UNIQUE_MIN_CHARS))
                                 && (len <= 5'(UNIQUE_MAX_CHARS));
                SEG_CHECK:  ok = (len >= 5'(CHECK_MIN_CHARS)) && (len <= 5'(CHECK_MAX_CHARS));
                default:    ok = 1'b0;
            endcase
            return ok;
        end
    endfunction

endpackage

// ===== rtl/sncv_char_class.sv =====
`timescale 1ns / 1ps

module sncv_char_class
    import sncv_pkg::*;
(
    input  logic [7:0]  char_code,
    output char_class_t cls
);

    logic [7:0] letter_k;
    logic [4:0] k;
    logic       skip_i;
    logic       skip_l;
    logic       skip_o;
    logic       skip_u;
    logic [4:0] letter_val;

    always_comb
    begin
        letter_k = char_code - CH_A;
        k        = letter_k[4:0];
        // I, L, O, U are dropped from the alphabet; later letters shift down
        skip_i   = (k > 5'd8);
        skip_l   = (k > 5'd11);
        skip_o   = (k > 5'd14);
        skip_u   = (k > 5'd20);
        letter_val = 5'd10 + k - 5'(skip_i) - 5'(skip_l) - 5'(skip_o) - 5'(skip_u);

        cls.is_dash  = (char_code == CH_DASH);
        cls.is_digit = (char_code >= CH_0) && (char_code <= CH_9);
        cls.is_upper = (char_code >= CH_A) && (char_code <= CH_Z);
        cls.crock_ok = cls.is_digit
                       || (cls.is_upper && (k != 5'd8) && (k != 5'd11)
                           && (k != 5'd14) && (k != 5'd20));
        if (cls.is_digit)
        begin
            cls.crock_val = 5'(char_code - CH_0);
            cls.mod_val   = 6'(char_code - CH_0);
        end
        else
        begin
            cls.crock_val = letter_val;
            cls.mod_val   = 6'd10 + {1'b0, k};
        end
    end

endmodule

// ===== rtl/sncv_string_state.sv =====
`timescale 1ns / 1ps

module sncv_string_state
    import sncv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic        char_present,
    input  logic        last_char,
    input  char_class_t cls,
    input  logic [5:0]  max_length,
    output logic        res_valid,
    output result_t     res
);

    logic [2:0] seg_idx_reg,  seg_idx_next;
    logic [4:0] seg_len_reg,  seg_len_next;
    logic       bad_reg,      bad_next;
    logic [6:0] total_len_reg, total_len_next;
    logic [4:0] sum_even_reg, sum_even_next;
    logic [4:0] sum_odd_reg,  sum_odd_next;
    logic       parity_reg,   parity_next;
    logic [6:0] residue_reg,  residue_next;

    // values after this character, before the end-of-string clear
    logic [2:0] seg_idx_upd;
    logic [4:0] seg_len_upd;
    logic       bad_upd;
    logic [6:0] total_len_upd;
    logic [4:0] sum_even_upd;
    logic [4:0] sum_odd_upd;
    logic       parity_upd;
    logic [6:0] residue_upd;

    logic [4:0]  dbl;
    logic [9:0]  res_x;
    logic [19:0] quot_prod;
    logic [3:0]  quot;
    logic [9:0]  rem;
    logic        fmt_bad;
    logic [4:0]  luhn_sum;

    // residue step: 10r + d for digits, 100r + v == 3r + v (mod 97) for letters
    always_comb
    begin
        res_x     = 10'(residue_reg) * (cls.is_digit ? 10'd10 : 10'd3) + 10'(cls.mod_val);
        quot_prod = 20'(res_x) * 20'(MOD97_RECIP);
        quot      = quot_prod[19:16];
        rem       = res_x - 10'(quot) * MOD97;
        dbl       = {cls.crock_val[3:0], cls.crock_val[4]};  // 2d/32 + 2d%32
    end

    always_comb
    begin
        seg_idx_upd   = seg_idx_reg;
        seg_len_upd   = seg_len_reg;
        bad_upd       = bad_reg;
        total_len_upd = total_len_reg;
        sum_even_upd  = sum_even_reg;
        sum_odd_upd   = sum_odd_reg;
        parity_upd    = parity_reg;
        residue_upd   = residue_reg;

        if (char_present)
        begin
            if (total_len_reg != TOTAL_LEN_MAX)
            begin
                total_len_upd = total_len_reg + 7'd1;
            end
            if (cls.is_dash)
            begin
                if (!seg_len_ok(seg_idx_reg, seg_len_reg))
                begin
                    bad_upd = 1'b1;
                end
                if (seg_idx_reg >= SEG_CHECK)
                begin
                    bad_upd = 1'b1;
                end
                else
                begin
                    seg_idx_upd = seg_idx_reg + 3'd1;
                end
                seg_len_upd = 5'd0;
            end
            else
            begin
                if (seg_len_reg == SEG_LEN_MAX)
                begin
                    bad_upd = 1'b1;
                end
                else
                begin
                    seg_len_upd = seg_len_reg + 5'd1;
                end
                if (seg_idx_reg == SEG_CC)
                begin
                    if (!cls.is_upper)
                    begin
                        bad_upd = 1'b1;
                    end
                end
                else if (!cls.crock_ok)
                begin
                    bad_upd = 1'b1;
                end
                else
                begin
                    if (!parity_reg)
                    begin
                        sum_even_upd = sum_even_reg + dbl;
                        sum_odd_upd  = sum_odd_reg + cls.crock_val;
                    end
                    else
                    begin
                        sum_even_upd = sum_even_reg + cls.crock_val;
                        sum_odd_upd  = sum_odd_reg + dbl;
                    end
                    parity_upd  = !parity_reg;
                    residue_upd = rem[6:0];
                end
            end
        end
    end

    always_comb
    begin
        fmt_bad  = bad_upd || (seg_idx_upd < SEG_UNIQUE)
                   || !seg_len_ok(seg_idx_upd, seg_len_upd);
        luhn_sum = parity_upd ? sum_odd_upd : sum_even_upd;

        res.kind = KIND_NONE;
        res.pass = 1'b0;
        if (total_len_upd == 7'd0)
        begin
            res.status = STATUS_EMPTY;
        end
        else if (total_len_upd > {1'b0, max_length})
        begin
            res.status = STATUS_TOO_LONG;
        end
        else if (fmt_bad)
        begin
            res.status = STATUS_BAD;
        end
        else
        begin
            res.status = STATUS_OK;
            if (seg_idx_upd < SEG_CHECK)
            begin
                res.pass = 1'b1;
            end
            else if (seg_len_upd == 5'd1)
            begin
                res.kind = KIND_LUHN;
                res.pass = (luhn_sum == 5'd0);
            end
            else
            begin
                res.kind = KIND_MOD97;
                res.pass = (residue_upd == 7'd1);
            end
        end
        res_valid = accept && last_char;
    end

    always_comb
    begin
        seg_idx_next   = seg_idx_reg;
        seg_len_next   = seg_len_reg;
        bad_next       = bad_reg;
        total_len_next = total_len_reg;
        sum_even_next  = sum_even_reg;
        sum_odd_next   = sum_odd_reg;
        parity_next    = parity_reg;
        residue_next   = residue_reg;
        if (accept)
        begin
            if (last_char)
            begin
                seg_idx_next   = SEG_CC;
                seg_len_next   = 5'd0;
                bad_next       = 1'b0;
                total_len_next = 7'd0;
                sum_even_next  = 5'd0;
                sum_odd_next   = 5'd0;
                parity_next    = 1'b0;
                residue_next   = 7'd0;
            end
            else
            begin
                seg_idx_next   = seg_idx_upd;
                seg_len_next   = seg_len_upd;
                bad_next       = bad_upd;
                total_len_next = total_len_upd;
                sum_even_next  = sum_even_upd;
                sum_odd_next   = sum_odd_upd;
                parity_next    = parity_upd;
                residue_next   = residue_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_idx_reg   <= SEG_CC;
            seg_len_reg   <= 5'd0;
            bad_reg       <= 1'b0;
            total_len_reg <= 7'd0;
            sum_even_reg  <= 5'd0;
            sum_odd_reg   <= 5'd0;
            parity_reg    <= 1'b0;
            residue_reg   <= 7'd0;
        end
        else
        begin
            seg_idx_reg   <= seg_idx_next;
            seg_len_reg   <= seg_len_next;
            bad_reg       <= bad_next;
            total_len_reg <= total_len_next;
            sum_even_reg  <= sum_even_next;
            sum_odd_reg   <= sum_odd_next;
            parity_reg    <= parity_next;
            residue_reg   <= residue_next;
        end
    end

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_char |=> (total_len_reg == 7'd0) && (seg_idx_reg == SEG_CC)
                                && (residue_reg == 7'd0))
        else $error("string state not cleared after end of string");

    a_seg_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        seg_idx_reg <= SEG_CHECK)
        else $error("segment index past check segment");

    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(total_len_reg) && $stable(residue_reg))
        else $error("string state moved without an accepted word");

    a_residue_range: assert property (@(posedge clk) disable iff (!rst_n)
        residue_reg < 7'd97)
        else $error("residue not reduced mod 97");

endmodule

// ===== rtl/sncv_out_buf.sv =====
`timescale 1ns / 1ps

module sncv_out_buf
    import sncv_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_word,
    output logic    full,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_word
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_word_reg, out_word_next;
    result_t skid_word_reg, skid_word_next;
    logic    take;

    always_comb
    begin
        take            = out_valid_reg && !out_stall;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_word_next   = out_word_reg;
        skid_word_next  = skid_word_reg;
        if (skid_valid_reg)
        begin
            // input is stalled while the skid word waits
            if (take)
            begin
                out_word_next   = skid_word_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || take)
            begin
                out_word_next  = push_word;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_word_next  = push_word;
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held with empty output register");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !skid_valid_reg)
        else $error("result word pushed into full buffer");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !out_stall |=> out_valid_reg && !skid_valid_reg)
        else $error("skid word not moved to output");

endmodule

// ===== rtl/serial_number_check_verifier.sv =====
`timescale 1ns / 1ps

// Channel  | handshake           | payload
// ---------+---------------------+------------------------------------
// input    | in_valid / in_stall | char_code, char_present, last_char
// output   | out_valid/out_stall | status, check_kind, check_pass
// config   | cfg_write           | cfg_data (max_length)
//
// One character word per cycle while in_stall is low; each accepted word updates the
// Luhn sums and mod-97 step, and a string's result is registered in the output buffer.
// rst_n clears all string state and sets max_length to 32.
// A two-word output buffer lets input flow while one result waits; in_stall rises
// only when both result slots are occupied.

module serial_number_check_verifier
    import sncv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_code,
    input  logic       char_present,
    input  logic       last_char,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] status,
    output logic [1:0] check_kind,
    output logic       check_pass,
    input  logic       cfg_write,
    input  logic [5:0] cfg_data
);

    logic [5:0]  max_length_reg, max_length_next;
    logic        accept;
    logic        buf_full;
    logic        res_valid;
    char_class_t cls;
    result_t     res;
    result_t     out_word;

    always_comb
    begin
        max_length_next = cfg_write ? cfg_data : max_length_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= MAX_LENGTH_RESET;
        end
        else
        begin
            max_length_reg <= max_length_next;
        end
    end

    assign in_stall = buf_full;
    assign accept   = in_valid && !buf_full;

    sncv_char_class u_char_class (
        .char_code (char_code),
        .cls       (cls)
    );

    sncv_string_state u_string_state (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .char_present (char_present),
        .last_char    (last_char),
        .cls          (cls),
        .max_length   (max_length_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    sncv_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_word (res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    assign status     = out_word.status;
    assign check_kind = out_word.kind;
    assign check_pass = out_word.pass;

endmodule
